// File: rtl/core/bsm_pkg.sv
`timescale 1ns / 1ps

package bsm_pkg;

  // result codes
  typedef enum logic [1:0] {
    KIND_SCOPE     = 2'd0,
    KIND_ROOT      = 2'd1,
    KIND_UNMATCHED = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } bsm_kind_e;

  // byte codes that matter
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_OPEN    = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE   = 8'h7D;

  // fixed widths of the result word
  localparam int unsigned OUT_LINE_W = 20;
  localparam int unsigned OUT_CNT_W  = 7;

  // shift command for the cell chain, push and pop never both
  typedef struct packed {
    logic push;
    logic pop;
  } bsm_stack_ctl_t;

endpackage

// File: rtl/core/bsm_cell.sv
`timescale 1ns / 1ps

module bsm_cell import bsm_pkg::*; #(
  parameter int unsigned LINE_BITS = 20
) (
  input  logic                 clk_i,
  input  bsm_stack_ctl_t       ctl_i,
  input  logic [LINE_BITS-1:0] up_i,
  input  logic [LINE_BITS-1:0] down_i,
  output logic [LINE_BITS-1:0] data_o
);

  logic [LINE_BITS-1:0] data_d, data_q;

  always_comb begin
    priority if (ctl_i.push) begin
      data_d = up_i;
    end else if (ctl_i.pop) begin
      data_d = down_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/bsm_stack.sv
`timescale 1ns / 1ps

module bsm_stack import bsm_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned LINE_BITS   = 20
) (
  input  logic                 clk_i,
  input  bsm_stack_ctl_t       ctl_i,
  input  logic [LINE_BITS-1:0] push_data_i,
  output logic [LINE_BITS-1:0] top_o
);

  logic [LINE_BITS-1:0] cell_data [STACK_DEPTH];

  // cell 0 is the top, a push shifts toward the bottom
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [LINE_BITS-1:0] up, down;

    if (i == 0) begin : g_first
      assign up = push_data_i;
    end else begin : g_mid_up
      assign up = cell_data[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign down = cell_data[i];
    end else begin : g_mid_down
      assign down = cell_data[i+1];
    end

    bsm_cell #(
      .LINE_BITS(LINE_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl_i),
      .up_i  (up),
      .down_i(down),
      .data_o(cell_data[i])
    );
  end

  assign top_o = cell_data[0];

endmodule

// File: rtl/core/brace_scope_matcher.sv
`timescale 1ns / 1ps

// channel  | direction | handshake              | word
// ---------+-----------+------------------------+----------------------------------------
// in       | input     | in_valid_i/in_ready_o  | char_byte_i, end_of_file_i
// out      | output    | out_valid_o/out_ready_i| kind_o, start_line_o, end_line_o,
//          |           |                        | nest_level_o, unclosed_count_o
//
// one byte per cycle; a stalled result blocks input only while the output
// register stays full. push and pop are one shift of the cell chain, and the
// result enters the output register in the cycle after its byte is taken
// reset clears the stack pointer, line count, partial-line flag, error flag
// and output valid; cell contents are left as they are, the stack pointer says which are live

module brace_scope_matcher import bsm_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned LINE_BITS   = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_byte_i,
  input  logic                  end_of_file_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            kind_o,
  output logic [OUT_LINE_W-1:0] start_line_o,
  output logic [OUT_LINE_W-1:0] end_line_o,
  output logic [OUT_CNT_W-1:0]  nest_level_o,
  output logic [OUT_CNT_W-1:0]  unclosed_count_o
);

  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam logic [LINE_BITS-1:0] LINE_SAT = {LINE_BITS{1'b1}};
  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

  // control state
  logic [SP_W-1:0]      sp_d, sp_q;
  logic [LINE_BITS-1:0] nl_d, nl_q;
  logic                 partial_d, partial_q;
  logic                 err_d, err_q;

  // output register
  logic                  out_valid_d, out_valid_q;
  bsm_kind_e             kind_d, kind_q;
  logic [OUT_LINE_W-1:0] start_d, start_q;
  logic [OUT_LINE_W-1:0] end_d, end_q;
  logic [OUT_CNT_W-1:0]  nest_d, nest_q;
  logic [OUT_CNT_W-1:0]  uncl_d, uncl_q;

  logic                 in_fire;
  logic                 res_valid;
  logic [LINE_BITS-1:0] cur_line;
  logic [LINE_BITS-1:0] last_line;
  logic [LINE_BITS-1:0] top_line;
  logic [31:0]          cur_ext, last_ext, top_ext, sp_ext;
  bsm_stack_ctl_t       stk_ctl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // saturating line numbers
  assign cur_line  = (nl_q == LINE_SAT) ? nl_q : nl_q + LINE_BITS'(1);
  assign last_line = partial_q ? cur_line : nl_q;

  // fit line and count values to the fixed result widths
  assign cur_ext  = 32'(cur_line);
  assign last_ext = 32'(last_line);
  assign top_ext  = 32'(top_line);
  assign sp_ext   = 32'(sp_q);

  bsm_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .LINE_BITS  (LINE_BITS)
  ) u_stack (
    .clk_i      (clk_i),
    .ctl_i      (stk_ctl),
    .push_data_i(cur_line),
    .top_o      (top_line)
  );

  always_comb begin
    sp_d      = sp_q;
    nl_d      = nl_q;
    partial_d = partial_q;
    err_d     = err_q;
    stk_ctl   = '0;
    res_valid = 1'b0;
    kind_d    = kind_q;
    start_d   = start_q;
    end_d     = end_q;
    nest_d    = nest_q;
    uncl_d    = uncl_q;

    if (in_fire) begin
      if (end_of_file_i) begin
        // root scope, then back to a fresh file
        res_valid = 1'b1;
        kind_d    = KIND_ROOT;
        start_d   = OUT_LINE_W'(1);
        end_d     = last_ext[OUT_LINE_W-1:0];
        nest_d    = '0;
        uncl_d    = sp_ext[OUT_CNT_W-1:0];
        sp_d      = '0;
        nl_d      = '0;
        partial_d = 1'b0;
        err_d     = 1'b0;
      end else if (!err_q) begin
        if (char_byte_i == CHAR_NEWLINE) begin
          nl_d      = cur_line;
          partial_d = 1'b0;
        end else begin
          partial_d = 1'b1;
          if (char_byte_i == CHAR_OPEN) begin
            if (sp_q == SP_FULL) begin
              // brace dropped
              res_valid = 1'b1;
              kind_d    = KIND_OVERFLOW;
              start_d   = cur_ext[OUT_LINE_W-1:0];
              end_d     = '0;
              nest_d    = '0;
              uncl_d    = sp_ext[OUT_CNT_W-1:0];
            end else begin
              stk_ctl.push = 1'b1;
              sp_d         = sp_q + SP_W'(1);
            end
          end else if (char_byte_i == CHAR_CLOSE) begin
            res_valid = 1'b1;
            if (sp_q == '0) begin
              // close with nothing open: hold until end of file
              err_d   = 1'b1;
              kind_d  = KIND_UNMATCHED;
              start_d = '0;
              end_d   = cur_ext[OUT_LINE_W-1:0];
              nest_d  = '0;
              uncl_d  = '0;
            end else begin
              stk_ctl.pop = 1'b1;
              sp_d        = sp_q - SP_W'(1);
              kind_d      = KIND_SCOPE;
              start_d     = top_ext[OUT_LINE_W-1:0];
              end_d       = cur_ext[OUT_LINE_W-1:0];
              nest_d      = sp_ext[OUT_CNT_W-1:0];
              uncl_d      = '0;
            end
          end
        end
      end
    end

    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      nl_q        <= '0;
      partial_q   <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sp_q        <= sp_d;
      nl_q        <= nl_d;
      partial_q   <= partial_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only together with a new result
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      kind_q  <= kind_d;
      start_q <= start_d;
      end_q   <= end_d;
      nest_q  <= nest_d;
      uncl_q  <= uncl_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign start_line_o     = start_q;
  assign end_line_o       = end_q;
  assign nest_level_o     = nest_q;
  assign unclosed_count_o = uncl_q;

  // stack pointer never runs past the cell chain
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_FULL)
    else $error("stack pointer beyond depth");

  // no push into a full chain, no pop from an empty one
  a_no_bad_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stk_ctl.push && sp_q == SP_FULL) && !(stk_ctl.pop && sp_q == '0))
    else $error("stack shift out of range");

  // end of file leaves a clean state
  a_eof_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_file_i |=> sp_q == '0 && nl_q == '0 && !err_q && !partial_q)
    else $error("state not cleared after end of file");

  // while in error hold, any byte but end of file changes nothing
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !end_of_file_i && err_q |=> $stable(nl_q) && $stable(sp_q) && !out_valid_q)
    else $error("byte acted on during error hold");

  // a produced result shows up in the output register
  a_res_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("result lost");

endmodule

// File: bench/tb_brace_scope_matcher.sv
`timescale 1ns / 1ps

module tb_brace_scope_matcher;
  import bsm_pkg::*;

  // block configuration under test
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned LINE_BITS   = 20;

  // words to send in all, directed table included
  localparam int unsigned ITEM_TARGET = 1950;

  // watchdog limit; the slowest run has the longest gaps and stalls on every word
  localparam longint unsigned CYCLE_LIMIT = 64'd1_000_000;

  // one result word as the block reports it
  typedef struct packed {
    bsm_kind_e              kind;
    logic [OUT_LINE_W-1:0]  start_line;
    logic [OUT_LINE_W-1:0]  end_line;
    logic [OUT_CNT_W-1:0]   nest_level;
    logic [OUT_CNT_W-1:0]   unclosed_count;
  } scope_word_t;

  // one row of the directed table; typed rows carry the result read off by hand
  typedef struct {
    logic [7:0]  ch;
    logic        eof;
    bit          typed;
    scope_word_t want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            char_byte_i;
  logic                  end_of_file_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            kind_o;
  logic [OUT_LINE_W-1:0] start_line_o;
  logic [OUT_LINE_W-1:0] end_line_o;
  logic [OUT_CNT_W-1:0]  nest_level_o;
  logic [OUT_CNT_W-1:0]  unclosed_count_o;

  // predictor copy of the scope tracker
  logic [LINE_BITS-1:0] pred_stack [STACK_DEPTH];
  int unsigned          pred_depth;
  logic [LINE_BITS-1:0] pred_lines;
  bit                   pred_partial;
  bit                   pred_hold;

  // results still owed by the block, oldest first
  scope_word_t scope_expect_q[$];
  stim_row_t   dir_rows[$];

  // idle controls for both sides
  bit          send_idle_on;
  bit          recv_idle_on;
  int unsigned stall_left;
  int unsigned recv_roll;

  // bookkeeping
  int unsigned     err_cnt;
  int unsigned     item_cnt;
  int unsigned     file_cnt;
  int unsigned     checked_cnt;
  int unsigned     kind_seen [4];
  int unsigned     deepest;
  longint unsigned cycle_cnt;
  scope_word_t     got_want;

  brace_scope_matcher #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_byte_i      (char_byte_i),
    .end_of_file_i    (end_of_file_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .start_line_o     (start_line_o),
    .end_line_o       (end_line_o),
    .nest_level_o     (nest_level_o),
    .unclosed_count_o (unclosed_count_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // next line number, held at the top once all line bits are set
  function automatic logic [LINE_BITS-1:0] line_after(input logic [LINE_BITS-1:0] v);
    return (v == {LINE_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  // any byte that is neither a newline nor a brace
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_NEWLINE || b == CHAR_OPEN || b == CHAR_CLOSE);
    return b;
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!send_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // stack cells keep their contents, only the pointer says what is live
  task automatic clear_scope_state();
    pred_depth   = 0;
    pred_lines   = '0;
    pred_partial = 1'b0;
    pred_hold    = 1'b0;
  endtask

  // works out the result of one word and advances the predictor state
  task automatic predict_scope(input logic [7:0] ch, input logic eof,
                               output bit hit, output scope_word_t w);
    logic [LINE_BITS-1:0] cur;
    hit = 1'b0;
    w   = '0;
    if (eof) begin
      // root scope, reported even while holding after an error
      hit              = 1'b1;
      w.kind           = KIND_ROOT;
      w.start_line     = OUT_LINE_W'(1);
      w.end_line       = pred_partial ? line_after(pred_lines) : pred_lines;
      w.unclosed_count = pred_depth[OUT_CNT_W-1:0];
      clear_scope_state();
    end else if (!pred_hold) begin
      if (ch == CHAR_NEWLINE) begin
        pred_lines   = line_after(pred_lines);
        pred_partial = 1'b0;
      end else begin
        // any other byte sits on the line after the completed ones
        pred_partial = 1'b1;
        cur          = line_after(pred_lines);
        if (ch == CHAR_OPEN) begin
          if (pred_depth >= STACK_DEPTH) begin
            // full stack: brace is dropped
            hit              = 1'b1;
            w.kind           = KIND_OVERFLOW;
            w.start_line     = cur;
            w.unclosed_count = pred_depth[OUT_CNT_W-1:0];
          end else begin
            pred_stack[pred_depth] = cur;
            pred_depth++;
          end
        end else if (ch == CHAR_CLOSE) begin
          hit        = 1'b1;
          w.end_line = cur;
          if (pred_depth == 0) begin
            // stray close: ignore everything up to end of file
            pred_hold = 1'b1;
            w.kind    = KIND_UNMATCHED;
          end else begin
            w.kind       = KIND_SCOPE;
            w.nest_level = pred_depth[OUT_CNT_W-1:0];
            pred_depth--;
            w.start_line = pred_stack[pred_depth];
          end
        end
      end
    end
  endtask

  // presents one word at a falling edge and holds it until it is taken
  task automatic send_word(input logic [7:0] ch, input logic eof, input bit typed,
                           input scope_word_t want);
    int unsigned gap;
    bit          hit;
    scope_word_t w;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_byte_i   = ch;
    end_of_file_i = eof;
    in_valid_i    = 1'b1;
    do @(posedge clk_i);
    while (!in_ready_o);
    predict_scope(ch, eof, hit, w);
    if (typed) scope_expect_q.insert(scope_expect_q.size(), want);
    else if (hit) scope_expect_q.insert(scope_expect_q.size(), w);
    item_cnt++;
    if (eof) file_cnt++;
    @(negedge clk_i);
  endtask

  // sender pauses until every owed result has come back
  task automatic wait_for_results();
    in_valid_i = 1'b0;
    while (scope_expect_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eof, input bit typed,
                         input bsm_kind_e kind, input int unsigned s, input int unsigned e,
                         input int unsigned lvl, input int unsigned unc);
    stim_row_t row;
    row.ch                  = ch;
    row.eof                 = eof;
    row.typed               = typed;
    row.want.kind           = kind;
    row.want.start_line     = OUT_LINE_W'(s);
    row.want.end_line       = OUT_LINE_W'(e);
    row.want.nest_level     = OUT_CNT_W'(lvl);
    row.want.unclosed_count = OUT_CNT_W'(unc);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // receiver: ready at random with stalls, mostly short, a few long
  always @(negedge clk_i) begin
    if (!recv_idle_on) begin
      out_ready_i = 1'b1;
    end else if (stall_left != 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      recv_roll = $urandom_range(0, 99);
      if (recv_roll < 70) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b0;
        if (recv_roll < 92) stall_left = $urandom_range(0, 2);
        else if (recv_roll < 98) stall_left = $urandom_range(3, 10);
        else stall_left = $urandom_range(20, 50);
      end
    end
  end

  // result checker: every taken word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (scope_expect_q.size() == 0) begin
        $display("%0t: result with none expected: kind %0d start %0d end %0d level %0d open %0d",
                 $time, kind_o, start_line_o, end_line_o, nest_level_o, unclosed_count_o);
        err_cnt++;
      end else begin
        got_want = scope_expect_q.pop_front();
        check_field("kind", 32'(got_want.kind), 32'(kind_o));
        check_field("start_line", 32'(got_want.start_line), 32'(start_line_o));
        check_field("end_line", 32'(got_want.end_line), 32'(end_line_o));
        check_field("nest_level", 32'(got_want.nest_level), 32'(nest_level_o));
        check_field("unclosed_count", 32'(got_want.unclosed_count), 32'(unclosed_count_o));
        checked_cnt++;
        kind_seen[got_want.kind]++;
        if (got_want.nest_level > deepest) deepest = got_want.nest_level;
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, scope_expect_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned roll;
    int unsigned pick;
    int unsigned depth;
    logic [7:0]  ch;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_byte_i   = 8'h00;
    end_of_file_i = 1'b0;
    send_idle_on  = 1'b1;
    recv_idle_on  = 1'b1;
    stall_left    = 0;
    err_cnt       = 0;
    item_cnt      = 0;
    file_cnt      = 0;
    checked_cnt   = 0;
    deepest       = 0;
    cycle_cnt     = 0;
    for (i = 0; i < 4; i++) kind_seen[i] = 0;
    clear_scope_state();

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    // empty file right after reset: root ends on line 0
    add_row(8'h00, 1'b1, 1'b1, KIND_ROOT, 1, 0, 0, 0);
    // stray close on an empty stack, then hold until end of file
    add_row(CHAR_CLOSE, 1'b0, 1'b1, KIND_UNMATCHED, 0, 1, 0, 0);
    add_row(CHAR_OPEN, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_NEWLINE, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(8'hFF, 1'b1, 1'b1, KIND_ROOT, 1, 1, 0, 0);
    // nested pair over several lines, carriage return is a plain byte
    add_row(8'h00, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_NEWLINE, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_OPEN, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(8'h0D, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_NEWLINE, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_OPEN, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_CLOSE, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(8'hFF, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_NEWLINE, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_CLOSE, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    // one close too many after balanced text in the same file
    add_row(CHAR_CLOSE, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_OPEN, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(8'h41, 1'b1, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    // file of one newline: no partial line, root ends on line 1
    add_row(CHAR_NEWLINE, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(CHAR_CLOSE, 1'b1, 1'b1, KIND_ROOT, 1, 1, 0, 0);
    // brace left open at end of file, byte on the end word is ignored
    add_row(CHAR_OPEN, 1'b0, 1'b0, KIND_SCOPE, 0, 0, 0, 0);
    add_row(8'h80, 1'b1, 1'b1, KIND_ROOT, 1, 1, 0, 1);
    add_row(8'h7F, 1'b1, 1'b1, KIND_ROOT, 1, 0, 0, 0);

    for (i = 0; i < dir_rows.size(); i++) begin
      send_word(dir_rows[i].ch, dir_rows[i].eof, dir_rows[i].typed, dir_rows[i].want);
    end

    // sender holds off until the block has drained
    wait_for_results();

    // random files
    while (item_cnt < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      // some files run with no idling on one side or both
      send_idle_on = ($urandom_range(0, 6) != 0);
      recv_idle_on = ($urandom_range(0, 6) != 0);
      if (roll < 8) begin
        // nest to near or past the stack depth, then close from none to two more than sent
        n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) send_word(CHAR_NEWLINE, 1'b0, 1'b0, '0);
          send_word(CHAR_OPEN, 1'b0, 1'b0, '0);
        end
        n = $urandom_range(0, n + 2);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) send_word(CHAR_NEWLINE, 1'b0, 1'b0, '0);
          send_word(CHAR_CLOSE, 1'b0, 1'b0, '0);
        end
      end else if (roll < 80) begin
        // balanced text with random content
        depth = 0;
        n = $urandom_range(1, 40);
        for (i = 0; i < n; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 20) begin
            ch = CHAR_NEWLINE;
          end else if (pick < 38 && depth < 12) begin
            ch = CHAR_OPEN;
            depth++;
          end else if (pick < 56 && depth > 0) begin
            ch = CHAR_CLOSE;
            depth--;
          end else begin
            ch = plain_byte();
          end
          send_word(ch, 1'b0, 1'b0, '0);
        end
        // close what is open, except for some files left unclosed
        if (roll >= 68 || $urandom_range(0, 3) != 0) begin
          while (depth > 0) begin
            send_word(CHAR_CLOSE, 1'b0, 1'b0, '0);
            depth--;
          end
        end
        // broken file: stray close, then bytes the block must swallow
        if (roll >= 68) begin
          send_word(CHAR_CLOSE, 1'b0, 1'b0, '0);
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end
      end else begin
        // noise heavy in braces and newlines
        n = $urandom_range(1, 30);
        for (i = 0; i < n; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) ch = CHAR_OPEN;
          else if (pick < 30) ch = CHAR_CLOSE;
          else if (pick < 45) ch = CHAR_NEWLINE;
          else ch = 8'($urandom_range(0, 255));
          send_word(ch, 1'b0, 1'b0, '0);
        end
      end
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    // drain and let the output stage settle
    wait_for_results();
    repeat (8) @(negedge clk_i);

    $display("covered %0d words in %0d files, %0d results checked",
             item_cnt, file_cnt, checked_cnt);
    $display("scope %0d, root %0d, unmatched %0d, overflow %0d, deepest level %0d",
             kind_seen[KIND_SCOPE], kind_seen[KIND_ROOT], kind_seen[KIND_UNMATCHED],
             kind_seen[KIND_OVERFLOW], deepest);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bsm_pkg.sv
rtl/core/bsm_cell.sv
rtl/core/bsm_stack.sv
rtl/core/brace_scope_matcher.sv
bench/tb_brace_scope_matcher.sv
